// ===== rtl/core/sorted_key_value_table_assert.svh =====
// Assertion macros for the sorted key/value table RTL, used by skvt_ctrl.
// Needs nothing else; each macro takes clock and active-low reset by name.
`ifndef SORTED_KEY_VALUE_TABLE_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SKVT_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sorted table check failed");

// Next-cycle implication, disabled during reset.
`define SKVT_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sorted table check failed");

`endif

// ===== rtl/core/skvt_pkg.sv =====
// Package for the sorted key/value table: sizes, codes and payload structs.
// Used by every module of the block; depends on nothing.
package skvt_pkg;

    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 64;
    localparam int IDX_BITS   = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int KEY_BITS   = 32;
    localparam int SLOT_W     = 6;
    localparam int OCC_W      = 7;
    localparam int WORD_W     = 64;

    // request types
    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_GET    = 2'd1;
    localparam logic [1:0] REQ_ADD    = 2'd2;
    localparam logic [1:0] REQ_WEAK   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_ABSENT   = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic signed [KEY_BITS-1:0] key;
        logic [WORD_W-1:0]          data_word;
        logic                       data_is_nil;
    } t_request;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] entry_value;
        logic              entry_nil;
        logic [OCC_W-1:0]  occupancy;
    } t_result;

    // one stored table entry
    typedef struct packed {
        logic signed [KEY_BITS-1:0] key;
        logic [VALUE_BITS-1:0]      value;
        logic                       nil;
    } t_entry;

    // access from the sequencer to the entry store
    typedef struct packed {
        logic                we;
        logic [IDX_BITS-1:0] waddr;
        t_entry              wdata;
        logic [IDX_BITS-1:0] raddr;
    } t_mem_req;

    // handshake status from the sequencer
    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_ctrl_status;

endpackage

// ===== rtl/core/skvt_store.sv =====
// Entry store of the sorted key/value table: one write port, one registered read port.
// Depends on skvt_pkg for the entry type and depth.
module skvt_store import skvt_pkg::*; (
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rdata
);

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    // write one entry
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // register the read every cycle
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/skvt_ctrl.sv =====
// Sequencer of the sorted key/value table: binary search with one shared key
// comparator, then an entry-by-entry shift for inserts. Depends on skvt_pkg.
module skvt_ctrl import skvt_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  t_request     i_request,
    input  logic         i_out_free,
    input  t_entry       i_rdata,
    output t_mem_req     o_mem,
    output t_ctrl_status o_status,
    output t_result      o_result
);

    `include "sorted_key_value_table_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_SRCH, S_SCMP, S_FCHK, S_DECIDE, S_SHIFT, S_SHWR, S_INS
    } t_state;

    t_state              r_state;
    t_request            r_req;
    logic [CNT_BITS-1:0] r_lo;
    logic [CNT_BITS-1:0] r_hi;
    logic [CNT_BITS-1:0] r_j;
    logic [CNT_BITS-1:0] r_count;
    logic                r_found;
    logic [VALUE_BITS-1:0] r_old_val;
    logic                r_old_nil;
    logic                r_done;
    t_result             r_res;

    logic [CNT_BITS:0]     w_sum;
    logic [CNT_BITS-1:0]   w_mid;
    logic [CNT_BITS-1:0]   w_jm1;
    logic                  w_key_lt;
    logic                  w_key_eq;
    logic                  w_new_nil;
    logic [VALUE_BITS-1:0] w_new_val;
    logic                  w_upd;

    // shared comparator against the stored key just read
    assign w_key_lt = i_rdata.key < r_req.key;
    assign w_key_eq = i_rdata.key == r_req.key;

    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid = w_sum[CNT_BITS:1];
    assign w_jm1 = r_j - CNT_BITS'(1);

    // value to store; nil values store a zero word
    assign w_new_nil = (r_req.req_type == REQ_GET) || r_req.data_is_nil;
    assign w_new_val = w_new_nil ? '0 : VALUE_BITS'(r_req.data_word);
    assign w_upd     = (r_req.req_type == REQ_ADD) ||
                       ((r_req.req_type == REQ_WEAK) && r_old_nil);

    // drive the store ports from the state
    always_comb begin
        o_mem       = '0;
        o_mem.raddr = w_mid[IDX_BITS-1:0];
        unique case (r_state)
            S_SRCH: begin
                o_mem.raddr = (r_lo < r_hi) ? w_mid[IDX_BITS-1:0] : r_lo[IDX_BITS-1:0];
            end
            S_SHIFT: begin
                o_mem.raddr = w_jm1[IDX_BITS-1:0];
            end
            S_SHWR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_j[IDX_BITS-1:0];
                o_mem.wdata = i_rdata;
            end
            S_DECIDE: begin
                o_mem.we          = r_found && w_upd;
                o_mem.waddr       = r_lo[IDX_BITS-1:0];
                o_mem.wdata.key   = r_req.key;
                o_mem.wdata.value = w_new_val;
                o_mem.wdata.nil   = w_new_nil;
            end
            S_INS: begin
                o_mem.we          = 1'b1;
                o_mem.waddr       = r_lo[IDX_BITS-1:0];
                o_mem.wdata.key   = r_req.key;
                o_mem.wdata.value = w_new_val;
                o_mem.wdata.nil   = w_new_nil;
            end
            default: begin
            end
        endcase
    end

    // sequencer state and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (r_done) begin
                        // hold the result until the output register can take it
                        if (i_out_free) begin
                            r_done <= 1'b0;
                        end
                    end else if (i_start) begin
                        r_req   <= i_request;
                        r_lo    <= '0;
                        r_hi    <= r_count;
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (r_lo < r_hi) begin
                        r_state <= S_SCMP;
                    end else if (r_lo < r_count) begin
                        r_state <= S_FCHK;
                    end else begin
                        r_found <= 1'b0;
                        r_state <= S_DECIDE;
                    end
                end
                S_SCMP: begin
                    if (w_key_lt) begin
                        r_lo <= w_mid + CNT_BITS'(1);
                    end else begin
                        r_hi <= w_mid;
                    end
                    r_state <= S_SRCH;
                end
                S_FCHK: begin
                    r_found   <= w_key_eq;
                    r_old_val <= i_rdata.value;
                    r_old_nil <= i_rdata.nil;
                    r_state   <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_res.slot      <= SLOT_W'(r_lo);
                    r_res.occupancy <= OCC_W'(r_count);
                    if (r_found) begin
                        r_res.status      <= ST_FOUND;
                        r_res.entry_value <= WORD_W'(w_upd ? w_new_val : r_old_val);
                        r_res.entry_nil   <= w_upd ? w_new_nil : r_old_nil;
                        r_done            <= 1'b1;
                        r_state           <= S_IDLE;
                    end else if ((r_req.req_type == REQ_LOOKUP) ||
                                 (r_count >= CNT_BITS'(CAPACITY))) begin
                        r_res.status      <= (r_req.req_type == REQ_LOOKUP) ?
                                             ST_ABSENT : ST_FULL;
                        r_res.entry_value <= '0;
                        r_res.entry_nil   <= 1'b0;
                        r_done            <= 1'b1;
                        r_state           <= S_IDLE;
                    end else begin
                        r_j     <= r_count;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    r_state <= (r_j > r_lo) ? S_SHWR : S_INS;
                end
                S_SHWR: begin
                    r_j     <= w_jm1;
                    r_state <= S_SHIFT;
                end
                S_INS: begin
                    r_count           <= r_count + CNT_BITS'(1);
                    r_res.status      <= ST_INSERTED;
                    r_res.slot        <= SLOT_W'(r_lo);
                    r_res.entry_value <= WORD_W'(w_new_val);
                    r_res.entry_nil   <= w_new_nil;
                    r_res.occupancy   <= OCC_W'(r_count + CNT_BITS'(1));
                    r_done            <= 1'b1;
                    r_state           <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_status.idle      = (r_state == S_IDLE) && !r_done;
    assign o_status.res_valid = (r_state == S_IDLE) && r_done && i_out_free;
    assign o_result           = r_res;

    // the table never holds more than its capacity
    `SKVT_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CNT_BITS'(CAPACITY))
    // the count moves only when a new entry is written
    `SKVT_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, r_state != S_INS, $stable(r_count))
    // a shift write always lands above the insertion point
    `SKVT_ASSERT_NOW(a_shift_above, i_clk, i_rst_n, r_state == S_SHWR, r_j > r_lo)
    // an insert happens only with room in the table
    `SKVT_ASSERT_NOW(a_ins_room, i_clk, i_rst_n, r_state == S_INS,
        r_count < CNT_BITS'(CAPACITY))

endmodule

// ===== rtl/core/sorted_key_value_table.sv =====
// Top level of the sorted key/value table: sequencer, entry store, output register.
// Depends on skvt_pkg, skvt_store and skvt_ctrl.
//
//  channel   direction  handshake               payload
//  request   in         i_in_valid / o_in_stall i_in_request (t_request)
//  result    out        o_out_valid / i_out_stall o_out_result (t_result)
//
// A request runs a binary search over the n stored entries through the single
// registered read port; an insert at point p then shifts the entries above p
// up one entry per pass. o_in_stall is high from acceptance until the result
// moves into the output register. Reset empties the table at once, no sweep.
// A stalled result holds in the output register; one more result can wait
// inside the sequencer behind it.
module sorted_key_value_table import skvt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_request i_in_request,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_result  o_out_result
);

    t_mem_req     w_mem;
    t_entry       w_rdata;
    t_ctrl_status w_status;
    t_result      w_result;
    logic         w_out_free;
    logic         r_out_valid;
    t_result      r_out_result;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_status.idle;

    skvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in_valid && w_status.idle),
        .i_request  (i_in_request),
        .i_out_free (w_out_free),
        .i_rdata    (w_rdata),
        .o_mem      (w_mem),
        .o_status   (w_status),
        .o_result   (w_result)
    );

    skvt_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    // load the output register, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_status.res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_status.res_valid) begin
            r_out_result <= w_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_result = r_out_result;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the sorted key/value table: a queued request driver with
// a table model, a result monitor, random input gaps, and random and long output stalls.
// Depends on skvt_pkg and the sorted_key_value_table top level.
`timescale 1ns / 100ps

module tb_top;
    import skvt_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 10;
    localparam int LIMIT_CYCLES = 800_000;
    localparam int TAIL_CYCLES  = 200;
    localparam int HOLD_CYCLES  = 500;
    localparam int MAX_GAP      = 19;
    localparam int MAX_PRINTS   = 40;

    localparam logic signed [KEY_BITS-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_BITS-1:0] KEY_MAX = 32'sh7fff_ffff;
    localparam logic [WORD_W-1:0] VALUE_MASK = ~({WORD_W{1'b1}} << VALUE_BITS);

    typedef struct packed {
        t_request req;
        logic     drain;
    } t_queued_req;

    logic     i_clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    t_request in_req = '0;
    logic     out_valid;
    logic     out_stall = 1'b1;
    t_result  out_res;

    // requests waiting to be driven, and results owed by the block
    t_queued_req request_backlog[$];
    t_result     owed_results[$];
    logic signed [KEY_BITS-1:0] written_keys[$];
    bit          backlog_filled = 1'b0;

    // model of the table contents
    logic signed [KEY_BITS-1:0] tbl_key[CAPACITY];
    logic [WORD_W-1:0]          tbl_val[CAPACITY];
    logic                       tbl_nil[CAPACITY];
    int                         tbl_count = 0;

    int n_sent = 0;
    int n_done = 0;
    int n_errors = 0;

    // driver state
    t_queued_req cur_req;
    bit          have_req = 1'b0;
    int          gap_left = 0;
    bit          tx_burst = 1'b0;

    // receiver state
    int  stall_left = 0;
    bit  rx_burst = 1'b0;
    int  hold_left = 0;
    int  next_hold_at = 120;
    logic hold_on;

    sorted_key_value_table u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_in_request (in_req),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_result (out_res)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // store a value word, forcing nil entries to read back zero
    function automatic void write_entry(input int pos, input logic [WORD_W-1:0] d,
                                        input logic dn);
        tbl_val[pos] = dn ? '0 : (d & VALUE_MASK);
        tbl_nil[pos] = dn;
    endfunction

    // apply one request to the table model and return the result it gives
    function automatic t_result apply_request(input t_request rq);
        t_result                    r;
        logic signed [KEY_BITS-1:0] k;
        int                         pos;
        bit                         hit;
        r = '0;
        k = rq.key;
        pos = 0;
        while (pos < tbl_count && tbl_key[pos] < k) pos++;
        hit = (pos < tbl_count) && (tbl_key[pos] == k);
        if (hit) begin
            r.status = ST_FOUND;
            if (rq.req_type == REQ_ADD || (rq.req_type == REQ_WEAK && tbl_nil[pos]))
                write_entry(pos, rq.data_word, rq.data_is_nil);
            r.entry_value = tbl_val[pos];
            r.entry_nil   = tbl_nil[pos];
        end else if (rq.req_type == REQ_LOOKUP) begin
            r.status = ST_ABSENT;
        end else if (tbl_count >= CAPACITY) begin
            r.status = ST_FULL;
        end else begin
            // shift the upper part up by one and open the slot
            for (int j = tbl_count; j > pos; j--) begin
                tbl_key[j] = tbl_key[j-1];
                tbl_val[j] = tbl_val[j-1];
                tbl_nil[j] = tbl_nil[j-1];
            end
            tbl_key[pos] = k;
            if (rq.req_type == REQ_GET)
                write_entry(pos, '0, 1'b1);
            else
                write_entry(pos, rq.data_word, rq.data_is_nil);
            tbl_count++;
            r.status      = ST_INSERTED;
            r.entry_value = tbl_val[pos];
            r.entry_nil   = tbl_nil[pos];
        end
        r.slot      = pos[SLOT_W-1:0];
        r.occupancy = tbl_count[OCC_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (n_errors < MAX_PRINTS)
            $display("tb_top: mismatch on %s at %0t: got %h, want %h", what, $time, got, want);
        n_errors++;
    endtask

    task automatic queue_request(input logic [1:0] rt, input logic signed [KEY_BITS-1:0] k,
                                 input logic [WORD_W-1:0] d, input logic dn, input logic drain);
        t_queued_req q;
        q.req.req_type    = rt;
        q.req.key         = k;
        q.req.data_word   = d;
        q.req.data_is_nil = dn;
        q.drain           = drain;
        request_backlog.push_back(q);
        if (rt != REQ_LOOKUP) written_keys.push_back(k);
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic signed [KEY_BITS-1:0] pick_written_key();
        return written_keys[$urandom_range(0, written_keys.size() - 1)];
    endfunction

    // fill the backlog: directed requests, then three random phases
    initial begin
        logic signed [KEY_BITS-1:0] key_pool[24];
        logic signed [KEY_BITS-1:0] k;
        logic [1:0]                 rt;
        int                         r;
        for (int i = 0; i < 24; i++)
            key_pool[i] = (i < 8) ? KEY_BITS'(i * 3 - 10) : $urandom();

        // directed: empty table, nil handling, weak add, extremes of key and data
        queue_request(REQ_LOOKUP, 0, '0, 1'b0, 1'b0);
        queue_request(REQ_GET, 5, rand_word(), 1'b0, 1'b0);
        queue_request(REQ_GET, 5, rand_word(), 1'b0, 1'b0);
        queue_request(REQ_WEAK, 5, 64'h0123_4567_89ab_cdef, 1'b0, 1'b0);
        queue_request(REQ_WEAK, 5, 64'hfedc_ba98_7654_3210, 1'b0, 1'b0);
        queue_request(REQ_ADD, 5, {WORD_W{1'b1}}, 1'b1, 1'b0);
        queue_request(REQ_ADD, KEY_MIN, {WORD_W{1'b1}}, 1'b0, 1'b0);
        queue_request(REQ_ADD, KEY_MAX, '0, 1'b0, 1'b0);
        queue_request(REQ_LOOKUP, KEY_MIN, '0, 1'b0, 1'b0);
        queue_request(REQ_LOOKUP, KEY_MAX, '0, 1'b0, 1'b0);
        queue_request(REQ_LOOKUP, -1, '0, 1'b0, 1'b0);
        queue_request(REQ_WEAK, -1, 64'h5555_aaaa_5555_aaaa, 1'b1, 1'b0);
        queue_request(REQ_WEAK, 100, 64'ha5a5_a5a5_a5a5_a5a5, 1'b0, 1'b0);
        queue_request(REQ_ADD, 100, 64'h8000_0000_0000_0001, 1'b0, 1'b0);
        queue_request(REQ_GET, 100, rand_word(), 1'b1, 1'b0);
        queue_request(REQ_ADD, 7, 64'hdead_beef_dead_beef, 1'b1, 1'b0);
        queue_request(REQ_LOOKUP, 7, rand_word(), 1'b1, 1'b0);
        queue_request(REQ_GET, KEY_MIN + 1, '0, 1'b0, 1'b0);
        queue_request(REQ_WEAK, KEY_MAX, rand_word(), 1'b0, 1'b1);

        // small key pool: mostly hits on a half-full table
        for (int i = 0; i < 250; i++) begin
            rt = 2'($urandom_range(REQ_LOOKUP, REQ_WEAK));
            queue_request(rt, key_pool[$urandom_range(0, 23)], rand_word(),
                          $urandom_range(0, 3) == 0, i == 0 || $urandom_range(0, 79) == 0);
        end

        // fresh keys: fill the table, then run into refusals
        for (int i = 0; i < 150; i++) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                rt = 2'($urandom_range(REQ_GET, REQ_WEAK));
                k  = $urandom();
            end else if (r == 7) begin
                rt = REQ_LOOKUP;
                k  = $urandom();
            end else begin
                rt = 2'($urandom_range(REQ_LOOKUP, REQ_WEAK));
                k  = key_pool[$urandom_range(0, 23)];
            end
            queue_request(rt, k, rand_word(), $urandom_range(0, 3) == 0,
                          i == 0 || $urandom_range(0, 79) == 0);
        end

        // full table: hits, neighbors of stored keys, and fresh keys
        for (int i = 0; i < 250; i++) begin
            r  = $urandom_range(0, 9);
            rt = 2'($urandom_range(REQ_LOOKUP, REQ_WEAK));
            if (r < 6)
                k = pick_written_key();
            else if (r == 6)
                k = pick_written_key() + ($urandom_range(0, 1) ? 1 : -1);
            else
                k = $urandom();
            queue_request(rt, k, rand_word(), $urandom_range(0, 3) == 0,
                          i == 0 || $urandom_range(0, 79) == 0);
        end
        backlog_filled = 1'b1;
    end

    // driver: present one request at a time, idle between them at random
    always @(posedge i_clk) begin
        logic next_valid;
        bit   accepted;
        next_valid = in_valid;
        accepted   = in_valid && !in_stall;
        if (rst_n) begin
            if (accepted) begin
                owed_results.push_back(apply_request(in_req));
                n_sent <= n_sent + 1;
                next_valid = 1'b0;
                have_req   = 1'b0;
            end
            if (!next_valid) begin
                if (!have_req && request_backlog.size() > 0) begin
                    cur_req  = request_backlog.pop_front();
                    have_req = 1'b1;
                    if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
                    gap_left = (tx_burst || hold_on) ? 0 : $urandom_range(0, MAX_GAP);
                end
                if (have_req) begin
                    // hold a draining request until every owed result is back
                    if (cur_req.drain && (accepted || n_sent != n_done)) begin
                    end else if (gap_left > 0) begin
                        gap_left--;
                    end else begin
                        next_valid = 1'b1;
                        in_req <= cur_req.req;
                    end
                end
            end
        end
        in_valid <= next_valid;
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (n_done >= next_hold_at) begin
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + 400;
        end
    end
    assign hold_on = (hold_left != 0);

    // monitor: check each accepted result against the oldest owed one
    always @(posedge i_clk) begin
        t_result want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("result with no request owed", out_res.entry_value, '0);
                end else begin
                    want = owed_results.pop_front();
                    if (out_res.status != want.status)
                        report_mismatch("status", 64'(out_res.status), 64'(want.status));
                    if (out_res.slot != want.slot)
                        report_mismatch("slot", 64'(out_res.slot), 64'(want.slot));
                    if (out_res.entry_value != want.entry_value)
                        report_mismatch("entry_value", out_res.entry_value, want.entry_value);
                    if (out_res.entry_nil != want.entry_nil)
                        report_mismatch("entry_nil", 64'(out_res.entry_nil),
                                        64'(want.entry_nil));
                    if (out_res.occupancy != want.occupancy)
                        report_mismatch("occupancy", 64'(out_res.occupancy),
                                        64'(want.occupancy));
                end
                n_done <= n_done + 1;
                if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
                stall_left = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            end else if (out_valid && stall_left > 0) begin
                stall_left--;
            end
            out_stall <= hold_on || (stall_left > 0);
        end
    end

    // reset once, then wait for the backlog and all owed results to drain
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        while (!(backlog_filled && request_backlog.size() == 0 && !have_req && !in_valid
                 && n_done == n_sent && owed_results.size() == 0))
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // watchdog
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/skvt_pkg.sv
rtl/core/skvt_store.sv
rtl/core/skvt_ctrl.sv
rtl/core/sorted_key_value_table.sv
tb/sv/tb_top.sv
